### hdl/signed_div_by_invariant_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signed division block
// Shared concurrent assertion forms, clocked and disabled by reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_DIV_BY_INVARIANT_TOP_MACROS_SVH
`define SIGNED_DIV_BY_INVARIANT_TOP_MACROS_SVH

// Same-cycle implication.
`define SDBI_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("sdbi assertion failed");

// Next-cycle implication.
`define SDBI_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("sdbi assertion failed");

`endif

### hdl/sdbi_pkg.sv
// ----------------------------------------------------------------------------
// sdbi_pkg
// Types and fixed widths shared by the signed division block.
// ----------------------------------------------------------------------------
package sdbi_pkg;

   localparam int FIELD_WIDTH = 32;  // dividend, divisor and quotient ports
   localparam int SHIFT_WIDTH = 5;   // post shift field

   // Coefficient control/status from the magic unit to the datapath
   typedef struct packed {
      logic                   busy;       // derivation running, hold off beats
      logic                   zero;       // divisor is zero
      logic                   negative;   // divisor is negative
      logic [SHIFT_WIDTH-1:0] post_shift;
   } coef_ctl_type;

endpackage

### hdl/signed_div_by_invariant_top.sv
// ----------------------------------------------------------------------------
// signed_div_by_invariant_top
// Signed division by an invariant divisor using multiply-high.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_dividend
//   rsp      out        rsp_valid/rsp_stall  rsp_quotient, rsp_divide_by_zero
//   csr      in         csr_write_enable     csr_write_data (divisor)
//
// One beat per cycle while req_stall is low, through three register stages
// (input, product, result); a req beat passes the input and product registers
// before it reaches the result register. req_stall is high in the cycle of a
// divisor write. A nonzero divisor then keeps it high while the magic unit
// runs: the l search plus WORD_WIDTH+1 division steps. A new write restarts
// the derivation. Reset (synchronous) loads the coefficients for divisor one
// directly. rsp_stall freezes the whole pipe while a result is waiting in the
// result register, and req_stall then follows it.
// ----------------------------------------------------------------------------
`include "signed_div_by_invariant_top_macros.svh"

module signed_div_by_invariant_top #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [sdbi_pkg::FIELD_WIDTH-1:0] req_dividend,
   // response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [sdbi_pkg::FIELD_WIDTH-1:0] rsp_quotient,
   output logic                                    rsp_divide_by_zero,
   // divisor register
   input  logic                                    csr_write_enable,
   input  logic signed [sdbi_pkg::FIELD_WIDTH-1:0] csr_write_data
);

   logic [WORD_WIDTH-1:0]     magic;
   sdbi_pkg::coef_ctl_type    ctl;

   // coefficient derivation, off the beat path
   sdbi_magic #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_magic (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .magic            (magic),
      .ctl              (ctl)
   );

   logic                                    advance;
   logic                                    req_accept;

   logic                                    v1_ff;
   logic [WORD_WIDTH-1:0]                   n1_ff, n1_in;
   logic                                    v2_ff;
   logic [WORD_WIDTH-1:0]                   n2_ff;
   logic [WORD_WIDTH-1:0]                   hi_ff, hi_in;
   logic                                    rsp_valid_ff;
   logic signed [sdbi_pkg::FIELD_WIDTH-1:0] quotient_ff, quotient_in;
   logic                                    dbz_ff, dbz_in;

   logic signed [2*WORD_WIDTH-1:0]          prod;
   logic [WORD_WIDTH-1:0]                   q0;
   logic [WORD_WIDTH-1:0]                   q_shift;
   logic [WORD_WIDTH-1:0]                   q1;
   logic [WORD_WIDTH-1:0]                   q;

   // whole pipe moves together unless the result register is held
   assign advance    = !rsp_valid_ff || !rsp_stall;
   // a beat in the write cycle waits so that it sees the new divisor
   assign req_stall  = ctl.busy || csr_write_enable || !advance;
   assign req_accept = req_valid && !req_stall;

   assign n1_in = req_dividend[WORD_WIDTH-1:0];

   // stage 1 -> 2: high word of the signed product magic * n
   assign prod  = $signed(magic) * $signed(n1_ff);
   assign hi_in = prod[2*WORD_WIDTH-1:WORD_WIDTH];

   // stage 2 -> result: add n, arithmetic post shift, round toward zero, sign
   assign q0      = n2_ff + hi_ff;
   assign q_shift = WORD_WIDTH'($signed(q0) >>> ctl.post_shift);
   assign q1      = q_shift + WORD_WIDTH'(n2_ff[WORD_WIDTH-1]);
   assign q       = ctl.negative ? (~q1 + WORD_WIDTH'(1)) : q1;

   always_comb begin
      if (ctl.zero) begin
         quotient_in = '0;
         dbz_in      = 1'b1;
      end else begin
         quotient_in = sdbi_pkg::FIELD_WIDTH'($signed(q));
         dbz_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= req_accept;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff;
      end
      if (advance) begin
         n1_ff       <= n1_in;
         n2_ff       <= n1_ff;
         hi_ff       <= hi_in;
         quotient_ff <= quotient_in;
         dbz_ff      <= dbz_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quotient       = quotient_ff;
   assign rsp_divide_by_zero = dbz_ff;

   // no beat is taken while coefficients are being derived
   `SDBI_ASSERT_NOW(a_busy_stalls, clock, reset, ctl.busy, req_stall)
   // an accepted beat lands in the input register
   `SDBI_ASSERT_NEXT(a_accept_lands, clock, reset, req_accept, v1_ff)
   // a held result pipe does not lose the middle stage
   `SDBI_ASSERT_NEXT(a_hold_stage2, clock, reset, v2_ff && !advance, v2_ff)
   // divide by zero forces a zero quotient
   `SDBI_ASSERT_NOW(a_dbz_zero, clock, reset, rsp_valid && rsp_divide_by_zero,
                    rsp_quotient == '0)

endmodule

### hdl/sdbi_magic.sv
// ----------------------------------------------------------------------------
// sdbi_magic
// Derives magic multiplier, post shift and sign from a divisor write using a
// bit-serial search for l followed by a restoring division, one bit a cycle.
// ----------------------------------------------------------------------------
module sdbi_magic #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [sdbi_pkg::FIELD_WIDTH-1:0]    csr_write_data,
   output logic [WORD_WIDTH-1:0]               magic,
   output sdbi_pkg::coef_ctl_type              ctl
);

   localparam int LW = $clog2(WORD_WIDTH);
   localparam int SW = $clog2(WORD_WIDTH + 2);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DIVIDE
   } state_type;

   state_type                          state_ff, state_in;
   logic [WORD_WIDTH-1:0]              ad_ff, ad_in;
   logic [WORD_WIDTH-1:0]              pow_ff, pow_in;
   logic [LW-1:0]                      l_ff, l_in;
   logic [WORD_WIDTH-1:0]              rem_ff, rem_in;
   logic [WORD_WIDTH-1:0]              quo_ff, quo_in;
   logic [SW-1:0]                      step_ff, step_in;
   logic                               neg_pend_ff, neg_pend_in;
   logic [WORD_WIDTH-1:0]              magic_ff, magic_in;
   logic [sdbi_pkg::SHIFT_WIDTH-1:0]   shift_ff, shift_in;
   logic [sdbi_pkg::SHIFT_WIDTH-1:0]   shift_pend_ff, shift_pend_in;
   logic                               neg_ff, neg_in;
   logic                               zero_ff, zero_in;

   logic [WORD_WIDTH-1:0]              dw;
   logic                               dneg;
   logic [WORD_WIDTH-1:0]              dabs;
   logic [WORD_WIDTH:0]                trial;
   logic                               ge;

   assign dw   = csr_write_data[WORD_WIDTH-1:0];
   assign dneg = dw[WORD_WIDTH-1];
   assign dabs = dneg ? (~dw + WORD_WIDTH'(1)) : dw;

   // one restoring step; the first step has no doubling (top quotient bit)
   assign trial = (step_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign ge    = (trial >= {1'b0, ad_ff});

   always_comb begin
      state_in      = state_ff;
      ad_in         = ad_ff;
      pow_in        = pow_ff;
      l_in          = l_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      neg_pend_in   = neg_pend_ff;
      shift_pend_in = shift_pend_ff;
      magic_in      = magic_ff;
      shift_in      = shift_ff;
      neg_in        = neg_ff;
      zero_in       = zero_ff;
      unique case (state_ff)
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         ST_SEARCH: begin
            // smallest l with 2^l >= |d|
            if (pow_ff < ad_ff) begin
               pow_in = {pow_ff[WORD_WIDTH-2:0], 1'b0};
               l_in   = l_ff + LW'(1);
            end else begin
               if (l_ff == '0) begin
                  rem_in        = pow_ff;
                  shift_pend_in = '0;
               end else begin
                  rem_in        = pow_ff >> 1;
                  shift_pend_in = sdbi_pkg::SHIFT_WIDTH'(l_ff - LW'(1));
               end
               quo_in   = '0;
               step_in  = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in = ge ? WORD_WIDTH'(trial - {1'b0, ad_ff}) : trial[WORD_WIDTH-1:0];
            if (step_ff != '0) begin
               quo_in = {quo_ff[WORD_WIDTH-2:0], ge};
            end
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(WORD_WIDTH)) begin
               magic_in = quo_in + WORD_WIDTH'(1);
               shift_in = shift_pend_ff;
               neg_in   = neg_pend_ff;
               zero_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // a divisor write starts over from any state
      if (csr_write_enable) begin
         if (dabs == '0) begin
            magic_in = '0;
            shift_in = '0;
            neg_in   = 1'b0;
            zero_in  = 1'b1;
            state_in = ST_IDLE;
         end else begin
            ad_in       = dabs;
            neg_pend_in = dneg;
            pow_in      = WORD_WIDTH'(1);
            l_in        = '0;
            state_in    = ST_SEARCH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         magic_ff <= WORD_WIDTH'(1);   // divisor one
         shift_ff <= '0;
         neg_ff   <= 1'b0;
         zero_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         magic_ff <= magic_in;
         shift_ff <= shift_in;
         neg_ff   <= neg_in;
         zero_ff  <= zero_in;
      end
      ad_ff         <= ad_in;
      pow_ff        <= pow_in;
      l_ff          <= l_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      step_ff       <= step_in;
      neg_pend_ff   <= neg_pend_in;
      shift_pend_ff <= shift_pend_in;
   end

   assign magic          = magic_ff;
   assign ctl.busy       = (state_ff != ST_IDLE);
   assign ctl.zero       = zero_ff;
   assign ctl.negative   = neg_ff;
   assign ctl.post_shift = shift_ff;

endmodule

### sim/sdbi_quotient_checker.sv
// ----------------------------------------------------------------------------
// sdbi_quotient_checker
// Watches the divisor port and both beat channels of the signed division
// block, predicts each quotient by multiply-high and compares in order.
// ----------------------------------------------------------------------------
module sdbi_quotient_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [sdbi_pkg::FIELD_WIDTH-1:0] req_dividend,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [sdbi_pkg::FIELD_WIDTH-1:0] rsp_quotient,
   input  logic                             rsp_divide_by_zero,
   input  logic                             csr_write_enable,
   input  logic [sdbi_pkg::FIELD_WIDTH-1:0] csr_write_data,
   output int                               failures,
   output int                               outstanding
);

   localparam int FW = sdbi_pkg::FIELD_WIDTH;

   typedef struct packed {
      logic [FW-1:0] dividend;
      logic [FW-1:0] quotient;
      logic          by_zero;
   } quotient_beat_type;

   quotient_beat_type pending_quotients[$];

   // coefficients derived from the divisor
   logic [FW-1:0]                    divisor_word;
   logic [FW-1:0]                    magic_word;
   logic [sdbi_pkg::SHIFT_WIDTH-1:0] shift_amount;
   logic                             divisor_is_negative;

   function automatic void load_divisor(input logic [FW-1:0] value);
      logic [FW-1:0] magnitude;
      logic [63:0]   magic_full;
      int unsigned   l;
      divisor_word        = value;
      divisor_is_negative = value[FW-1];
      magnitude           = value[FW-1] ? -value : value;
      if (magnitude == '0) begin
         magic_word          = '0;
         shift_amount        = '0;
         divisor_is_negative = 1'b0;
      end else begin
         // ceil(log2 |d|), at least one
         l = 0;
         while (l < FW && (64'd1 << l) < {32'd0, magnitude})
            l++;
         if (l < 1)
            l = 1;
         magic_full   = 64'd1 + ((64'd1 << (FW + l - 1)) / {32'd0, magnitude});
         magic_word   = magic_full[FW-1:0];   // m - 2^32 wraps to the low word
         shift_amount = sdbi_pkg::SHIFT_WIDTH'(l - 1);
      end
   endfunction

   function automatic logic [FW-1:0] quotient_of(input logic [FW-1:0] n);
      longint               product;
      logic [FW-1:0]        high_word;
      logic signed [FW-1:0] q;
      product   = longint'($signed(magic_word)) * longint'($signed(n));
      high_word = product[63:32];
      q         = n + high_word;
      q         = q >>> shift_amount;
      q         = q + n[FW-1];
      if (divisor_is_negative)
         q = -q;
      return q;
   endfunction

   always @(posedge clock) begin
      quotient_beat_type want;
      int                bad;
      bad = 0;
      if (reset) begin
         pending_quotients.delete();
         load_divisor(1);
         failures    <= 0;
         outstanding <= 0;
      end else begin
         if (csr_write_enable)
            load_divisor(csr_write_data);
         // retire before admitting, so a stray beat cannot match a fresh one
         if (rsp_valid && !rsp_stall) begin
            if (pending_quotients.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual q=%0d dbz=%b",
                        $time, $signed(rsp_quotient), rsp_divide_by_zero);
               bad++;
            end else begin
               want = pending_quotients.pop_front();
               if (rsp_quotient !== want.quotient) begin
                  $display("%0t: quotient of %0d: expected %0d, actual %0d",
                           $time, $signed(want.dividend), $signed(want.quotient),
                           $signed(rsp_quotient));
                  bad++;
               end
               if (rsp_divide_by_zero !== want.by_zero) begin
                  $display("%0t: divide_by_zero of %0d: expected %b, actual %b",
                           $time, $signed(want.dividend), want.by_zero,
                           rsp_divide_by_zero);
                  bad++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            want.dividend = req_dividend;
            want.by_zero  = (divisor_word == '0);
            want.quotient = want.by_zero ? '0 : quotient_of(req_dividend);
            pending_quotients.push_back(want);
         end
         failures    <= failures + bad;
         outstanding <= pending_quotients.size();
      end
   end

endmodule

### sim/signed_div_by_invariant_top_tb.sv
// ----------------------------------------------------------------------------
// signed_div_by_invariant_top_tb
// Drives dividends and divisor writes into the signed division block under
// random bursts and response stalls; a checker beside the block predicts
// every quotient and the divide-by-zero flag and counts mismatches.
// ----------------------------------------------------------------------------
module signed_div_by_invariant_top_tb;

   localparam int          FW            = sdbi_pkg::FIELD_WIDTH;
   localparam logic [31:0] MOST_NEGATIVE = 32'h8000_0000;
   localparam logic [31:0] MOST_POSITIVE = 32'h7FFF_FFFF;
   localparam int          RANDOM_ITEMS  = 1000;
   // watchdog limit, with a wide margin over the slowest run
   localparam int          CYCLE_LIMIT   = 400000;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic [FW-1:0] req_dividend;
   logic          rsp_valid;
   logic          rsp_stall;
   logic [FW-1:0] rsp_quotient;
   logic          rsp_divide_by_zero;
   logic          csr_write_enable;
   logic [FW-1:0] csr_write_data;

   int            failures;
   int            outstanding;
   int            cycle_count;

   // divisor the block currently holds, used to aim dividends at multiples
   logic [FW-1:0] divisor_now;
   // beats left in the current sender burst
   int            burst_left;

   signed_div_by_invariant_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_dividend       (req_dividend),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quotient       (rsp_quotient),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   // Predicts and compares; only the failure count and the number of beats
   // still in flight come back to this module.
   sdbi_quotient_checker quotient_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_dividend       (req_dividend),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quotient       (rsp_quotient),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .failures           (failures),
      .outstanding        (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** signed_div_by_invariant_top: FAILED **");
         $finish;
      end
   end

   // Receiver: stall probability switches among a few levels, held for a
   // random stretch, so there are runs with no stall at all and runs with
   // the pipe nearly frozen.
   initial begin
      int level;
      int stretch;
      rsp_stall = 1'b0;
      forever begin
         case ($urandom_range(0, 3))
            0:       level = 0;
            1:       level = 30;
            2:       level = 60;
            default: level = 90;
         endcase
         stretch = $urandom_range(8, 96);
         repeat (stretch) begin
            @(negedge clock);
            rsp_stall <= ($urandom_range(0, 99) < level);
         end
      end
   end

   // One dividend beat. Bursts of random length are separated by random gaps
   // (sometimes none); valid is held until the beat is taken.
   task automatic send_dividend(input logic [FW-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid    <= 1'b1;
      req_dividend <= value;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   // Divisor writes only land on an idle block: drop valid, drain every
   // beat in flight, then one write cycle. The block holds req_stall while it
   // derives the new coefficients, which send_dividend simply waits out.
   task automatic set_divisor(input logic [FW-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      wait (outstanding == 0);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      divisor_now = value;
      burst_left  = 0;
   endtask

   function automatic logic [FW-1:0] random_divisor();
      logic [FW-1:0] d;
      logic          may_flip;
      may_flip = 1'b1;
      case ($urandom_range(0, 9))
         0, 1:    d = $urandom_range(1, 16);
         2, 3:    d = 32'd1 << $urandom_range(0, 31);   // 2^31 is the most negative
         4, 5, 6: begin
            d        = $urandom;
            may_flip = 1'b0;
         end
         7:       d = $urandom_range(2, 1000);
         8: begin
            case ($urandom_range(0, 3))
               0:       d = MOST_POSITIVE;
               1:       d = MOST_NEGATIVE;
               2:       d = MOST_NEGATIVE + 1;
               default: d = 32'd1;
            endcase
            may_flip = 1'b0;
         end
         default: d = '0;
      endcase
      if (may_flip && $urandom_range(0, 1))
         d = -d;
      return d;
   endfunction

   // Dividends cluster on the rounding edges: exact multiples of the divisor
   // and one either side, plus small values, extremes and full-range noise.
   function automatic logic [FW-1:0] random_dividend();
      logic [FW-1:0] n;
      logic [FW-1:0] k;
      case ($urandom_range(0, 7))
         0, 1, 7: n = $urandom;
         2:       n = int'($urandom_range(0, 600)) - 300;
         3: begin
            case ($urandom_range(0, 6))
               0:       n = MOST_NEGATIVE;
               1:       n = MOST_POSITIVE;
               2:       n = MOST_NEGATIVE + 1;
               3:       n = MOST_POSITIVE - 1;
               4:       n = '0;
               5:       n = '1;
               default: n = 32'd1;
            endcase
         end
         default: begin
            k = int'($urandom_range(0, 4000)) - 2000;
            if ($urandom_range(0, 3) == 0)
               k = $urandom;
            n = divisor_now * k + (int'($urandom_range(0, 2)) - 1);
         end
      endcase
      return n;
   endfunction

   initial begin
      int random_sent;
      int phase_items;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_dividend     = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      cycle_count      = 0;
      divisor_now      = 32'd1;
      burst_left       = 0;
      random_sent      = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // reset divisor is one: identity, including the extremes
      send_dividend('0);
      send_dividend(32'd1);
      send_dividend('1);
      send_dividend(MOST_POSITIVE);
      send_dividend(MOST_NEGATIVE);
      send_dividend(MOST_NEGATIVE + 1);
      send_dividend(32'd12345);
      // most negative over minus one wraps back to itself
      set_divisor('1);
      send_dividend(MOST_NEGATIVE);
      send_dividend(MOST_POSITIVE);
      send_dividend('1);
      // zero divisor: quotient forced to zero, flag raised
      set_divisor('0);
      send_dividend('0);
      send_dividend(MOST_NEGATIVE);
      send_dividend(32'd77);
      // most negative divisor: only the most negative dividend gives one
      set_divisor(MOST_NEGATIVE);
      send_dividend(MOST_NEGATIVE);
      send_dividend(MOST_POSITIVE);
      send_dividend('1);
      send_dividend(MOST_NEGATIVE + 1);
      // power of two: shift uses ceil(log2), most negative must stay exact
      set_divisor(32'h4000_0000);
      send_dividend(MOST_NEGATIVE);
      send_dividend(-32'h4000_0000);
      send_dividend(32'h3FFF_FFFF);
      // ordinary divisor around the truncation boundary
      set_divisor(32'd7);
      send_dividend(-32'd7);
      send_dividend(-32'd6);
      send_dividend(32'd7);
      send_dividend(MOST_POSITIVE);
      set_divisor(MOST_POSITIVE);
      send_dividend(MOST_POSITIVE);
      send_dividend(MOST_NEGATIVE);

      // --- random part: a fresh divisor per phase ---
      while (random_sent < RANDOM_ITEMS) begin
         set_divisor(random_divisor());
         phase_items = $urandom_range(20, 80);
         repeat (phase_items) send_dividend(random_dividend());
         random_sent += phase_items;
      end

      // drain, then give the three-stage pipe time to show any stray beat
      @(negedge clock);
      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (10) @(posedge clock);
      if (failures == 0)
         $display("** signed_div_by_invariant_top: PASSED **");
      else
         $display("** signed_div_by_invariant_top: FAILED **");
      $finish;
   end

endmodule
